>>> src/rwp_pkg.sv
// Shared constants and types for the RIFF/WAVE header parser.
package rwp_pkg;

	localparam int POSITION_BITS_DEF = 32;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [31:0] FMT_MIN_LEN = 32'd16;
	localparam logic [3:0]  FMT_BITS_AT = 4'd14;

	localparam logic [2:0] PH_FILE = 3'd0;
	localparam logic [2:0] PH_HEAD = 3'd1;
	localparam logic [2:0] PH_BODY = 3'd2;
	localparam logic [2:0] PH_PAD  = 3'd3;
	localparam logic [2:0] PH_HALT = 3'd4;

	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_SMALL     = 4'd1;
	localparam logic [3:0] ST_NOT_RIFF  = 4'd2;
	localparam logic [3:0] ST_TRUNC     = 4'd3;
	localparam logic [3:0] ST_FMT_SHORT = 4'd4;
	localparam logic [3:0] ST_MISSING   = 4'd5;
	localparam logic [3:0] ST_NOT_PCM   = 4'd6;
	localparam logic [3:0] ST_ZERO_RATE = 4'd7;
	localparam logic [3:0] ST_LAYOUT    = 4'd8;
	localparam logic [3:0] ST_EMPTY     = 4'd9;

	localparam logic [1:0] LY_MONO8    = 2'd0;
	localparam logic [1:0] LY_STEREO8  = 2'd1;
	localparam logic [1:0] LY_MONO16   = 2'd2;
	localparam logic [1:0] LY_STEREO16 = 2'd3;

	typedef struct packed {
		logic [2:0]  phase;
		logic [3:0]  fault;
		logic [1:0]  flags;
		logic [15:0] coding;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [31:0] start;
		logic [31:0] size;
	} rwp_summary_t;

endpackage

>>> src/rwp_core.sv
// Chunk walker: parser state and its update for one file byte.
module rwp_core #(
	parameter int POS_BITS = rwp_pkg::POSITION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [7:0]           file_byte,
	input  logic                 final_byte,
	output rwp_pkg::rwp_summary_t summary
);

	logic [2:0]          phase_q, n_phase;
	logic [POS_BITS-1:0] pos_q, n_pos, pos_inc;
	logic [31:0]         tag_q, n_tag;
	logic [31:0]         len_q, n_len;
	logic [31:0]         left_q, n_left;
	logic                is_fmt_q, n_is_fmt;
	logic [15:0]         coding_q, n_coding;
	logic [15:0]         chan_q, n_chan;
	logic [31:0]         rate_q, n_rate;
	logic [15:0]         bits_q, n_bits;
	logic [1:0]          flags_q, n_flags;
	logic [POS_BITS-1:0] start_q, n_start;
	logic [31:0]         size_q, n_size;
	logic [3:0]          fault_q, n_fault;
	logic [31:0]         fmt_off;

	assign pos_inc = pos_q + {{(POS_BITS-1){1'b0}}, 1'b1};
	assign fmt_off = len_q - left_q;

	always_comb begin
		n_phase  = phase_q;
		n_pos    = pos_inc;
		n_tag    = tag_q;
		n_len    = len_q;
		n_left   = left_q;
		n_is_fmt = is_fmt_q;
		n_coding = coding_q;
		n_chan   = chan_q;
		n_rate   = rate_q;
		n_bits   = bits_q;
		n_flags  = flags_q;
		n_start  = start_q;
		n_size   = size_q;
		n_fault  = fault_q;
		unique case (phase_q)
			rwp_pkg::PH_FILE: begin
				n_tag = {file_byte, tag_q[31:8]};
				if (pos_q == POS_BITS'(3) && n_tag != rwp_pkg::TAG_RIFF &&
						n_fault == rwp_pkg::ST_OK)
					n_fault = rwp_pkg::ST_NOT_RIFF;
				if (pos_q == POS_BITS'(11)) begin
					if (n_tag != rwp_pkg::TAG_WAVE && n_fault == rwp_pkg::ST_OK)
						n_fault = rwp_pkg::ST_NOT_RIFF;
					n_phase = (n_fault != rwp_pkg::ST_OK) ? rwp_pkg::PH_HALT
						: rwp_pkg::PH_HEAD;
					n_left = '0;
				end
			end
			rwp_pkg::PH_HEAD: begin
				if (left_q < 32'd4)
					n_tag = {file_byte, tag_q[31:8]};
				else
					n_len = {file_byte, len_q[31:8]};
				n_left = left_q + 32'd1;
				if (n_left == 32'd8) begin
					n_is_fmt = (n_tag == rwp_pkg::TAG_FMT);
					if (n_is_fmt) begin
						if (n_len < rwp_pkg::FMT_MIN_LEN) begin
							if (n_fault == rwp_pkg::ST_OK)
								n_fault = rwp_pkg::ST_FMT_SHORT;
						end else begin
							n_flags[0] = 1'b1;
						end
					end else if (n_tag == rwp_pkg::TAG_DATA) begin
						n_flags[1] = 1'b1;
						n_start = pos_inc;
						n_size = n_len;
					end
					n_left = n_len;
					n_phase = rwp_pkg::PH_BODY;
					if (n_len == 32'd0)
						n_phase = (n_fault != rwp_pkg::ST_OK) ? rwp_pkg::PH_HALT
							: rwp_pkg::PH_HEAD;
				end
			end
			rwp_pkg::PH_BODY: begin
				if (is_fmt_q && fault_q == rwp_pkg::ST_OK && fmt_off[31:4] == 28'd0) begin
					unique case (fmt_off[3:0])
						4'd0: n_coding[7:0]  = file_byte;
						4'd1: n_coding[15:8] = file_byte;
						4'd2: n_chan[7:0]    = file_byte;
						4'd3: n_chan[15:8]   = file_byte;
						4'd4: n_rate[7:0]    = file_byte;
						4'd5: n_rate[15:8]   = file_byte;
						4'd6: n_rate[23:16]  = file_byte;
						4'd7: n_rate[31:24]  = file_byte;
						rwp_pkg::FMT_BITS_AT: n_bits[7:0] = file_byte;
						rwp_pkg::FMT_BITS_AT + 4'd1: n_bits[15:8] = file_byte;
						default: ;
					endcase
				end
				n_left = left_q - 32'd1;
				if (n_left == 32'd0) begin
					if (fault_q != rwp_pkg::ST_OK) begin
						n_phase = rwp_pkg::PH_HALT;
					end else if (len_q[0]) begin
						n_phase = rwp_pkg::PH_PAD;
					end else begin
						n_phase = rwp_pkg::PH_HEAD;
						n_left = '0;
					end
				end
			end
			rwp_pkg::PH_PAD: begin
				n_phase = rwp_pkg::PH_HEAD;
				n_left = '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		summary.phase    = n_phase;
		summary.fault    = n_fault;
		summary.flags    = n_flags;
		summary.coding   = n_coding;
		summary.channels = n_chan;
		summary.rate     = n_rate;
		summary.bits     = n_bits;
		summary.start    = 32'(n_start);
		summary.size     = n_size;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rwp_pkg::PH_FILE;
			pos_q    <= '0;
			tag_q    <= '0;
			len_q    <= '0;
			left_q   <= '0;
			is_fmt_q <= 1'b0;
			coding_q <= '0;
			chan_q   <= '0;
			rate_q   <= '0;
			bits_q   <= '0;
			flags_q  <= '0;
			start_q  <= '0;
			size_q   <= '0;
			fault_q  <= rwp_pkg::ST_OK;
		end else if (en && final_byte) begin
			phase_q  <= rwp_pkg::PH_FILE;
			pos_q    <= '0;
			tag_q    <= '0;
			len_q    <= '0;
			left_q   <= '0;
			is_fmt_q <= 1'b0;
			coding_q <= '0;
			chan_q   <= '0;
			rate_q   <= '0;
			bits_q   <= '0;
			flags_q  <= '0;
			start_q  <= '0;
			size_q   <= '0;
			fault_q  <= rwp_pkg::ST_OK;
		end else if (en) begin
			phase_q  <= n_phase;
			pos_q    <= n_pos;
			tag_q    <= n_tag;
			len_q    <= n_len;
			left_q   <= n_left;
			is_fmt_q <= n_is_fmt;
			coding_q <= n_coding;
			chan_q   <= n_chan;
			rate_q   <= n_rate;
			bits_q   <= n_bits;
			flags_q  <= n_flags;
			start_q  <= n_start;
			size_q   <= n_size;
			fault_q  <= n_fault;
		end
	end

endmodule

>>> src/rwp_status.sv
// Final verdict: status and layout code from the parser summary.
module rwp_status (
	input  rwp_pkg::rwp_summary_t summary,
	output logic [3:0]            status,
	output logic [1:0]            layout_code
);

	logic [3:0] st;
	logic [1:0] ly;

	always_comb begin
		st = rwp_pkg::ST_OK;
		ly = rwp_pkg::LY_MONO8;
		priority if (summary.phase == rwp_pkg::PH_FILE) begin
			st = rwp_pkg::ST_SMALL;
		end else if (summary.fault == rwp_pkg::ST_NOT_RIFF) begin
			st = rwp_pkg::ST_NOT_RIFF;
		end else if (summary.phase == rwp_pkg::PH_BODY) begin
			st = rwp_pkg::ST_TRUNC;
		end else if (summary.fault != rwp_pkg::ST_OK) begin
			st = summary.fault;
		end else if (summary.flags != 2'b11) begin
			st = rwp_pkg::ST_MISSING;
		end else if (summary.coding != 16'd1) begin
			st = rwp_pkg::ST_NOT_PCM;
		end else if (summary.rate == 32'd0) begin
			st = rwp_pkg::ST_ZERO_RATE;
		end else if (summary.channels == 16'd1 && summary.bits == 16'd8) begin
			ly = rwp_pkg::LY_MONO8;
		end else if (summary.channels == 16'd2 && summary.bits == 16'd8) begin
			ly = rwp_pkg::LY_STEREO8;
		end else if (summary.channels == 16'd1 && summary.bits == 16'd16) begin
			ly = rwp_pkg::LY_MONO16;
		end else if (summary.channels == 16'd2 && summary.bits == 16'd16) begin
			ly = rwp_pkg::LY_STEREO16;
		end else begin
			st = rwp_pkg::ST_LAYOUT;
		end
		if (st == rwp_pkg::ST_OK && summary.size == 32'd0)
			st = rwp_pkg::ST_EMPTY;
		if (st != rwp_pkg::ST_OK)
			ly = rwp_pkg::LY_MONO8;
		status = st;
		layout_code = ly;
	end

endmodule

>>> src/riff_wave_header_parser.sv
// RIFF/WAVE header parser top level: input register, chunk walker, result register.
// The request carrying the last byte passes the input register, then the result register, before its result appears.
// Throughput: one byte per cycle unless a waiting result is stalled; the input register refills while it drains.
// A result waiting under stall holds the input side only when the input register is full.
// Reset (arst_n low) is asynchronous and returns the parser to the file header phase.
// After each last byte the parser returns to that same reset state by itself.
module riff_wave_header_parser #(
	parameter int POSITION_BITS = rwp_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  file_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [1:0]  layout_code,
	output logic [31:0] sample_rate,
	output logic [31:0] data_offset,
	output logic [31:0] data_length
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        adv;
	logic        en;
	logic        out_valid_q;
	logic [3:0]  status_q;
	logic [1:0]  layout_q;
	logic [31:0] rate_q;
	logic [31:0] offset_q;
	logic [31:0] length_q;
	logic [3:0]  st_c;
	logic [1:0]  ly_c;
	rwp_pkg::rwp_summary_t summary;

	assign adv      = !out_valid_q || !out_stall;
	assign en       = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= file_byte;
			last_s1 <= final_byte;
		end
	end

	rwp_core #(
		.POS_BITS(POSITION_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.file_byte (byte_s1),
		.final_byte(last_s1),
		.summary   (summary)
	);

	rwp_status u_status (
		.summary    (summary),
		.status     (st_c),
		.layout_code(ly_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= en && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && last_s1) begin
			status_q <= st_c;
			layout_q <= ly_c;
			rate_q   <= summary.rate;
			offset_q <= summary.start;
			length_q <= summary.size;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign layout_code = layout_q;
	assign sample_rate = rate_q;
	assign data_offset = offset_q;
	assign data_length = length_q;

endmodule

>>> src/rwp_checker.sv
// Port-level checks for the RIFF/WAVE header parser, bound to the top level.
module rwp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  status,
	input logic [1:0]  layout_code,
	input logic [31:0] sample_rate,
	input logic [31:0] data_length
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("result dropped or changed under stall");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= rwp_pkg::ST_EMPTY)
		else $error("status code out of range");

	a_layout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != rwp_pkg::ST_OK |-> layout_code == rwp_pkg::LY_MONO8)
		else $error("layout code set on a failed file");

	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rwp_pkg::ST_OK |-> sample_rate != 32'd0 && data_length != 32'd0)
		else $error("ok status with zero rate or empty data");

endmodule

bind riff_wave_header_parser rwp_checker u_rwp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.layout_code(layout_code),
	.sample_rate(sample_rate),
	.data_length(data_length)
);
